### rtl/assert_macros.svh
// Assertion macros shared by the helm sequencer RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

### rtl/tlhs_pkg.sv
// Shared constants and types for the timed-leg helm sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package tlhs_pkg;

   // window and tick counter
   localparam int WINDOW_LEN = 10;
   localparam int TICK_BITS  = 16;

   // datapath widths
   localparam int POS_W   = 24;
   localparam int MAG_W   = POS_W;
   localparam int SQ_W    = 2 * MAG_W + 1;
   localparam int DIST_W  = (SQ_W + 1) / 2;
   localparam int RAD_W   = 2 * DIST_W;
   localparam int SUM_W   = DIST_W + $clog2(WINDOW_LEN);
   localparam int PTR_W   = $clog2(WINDOW_LEN);
   localparam int FILL_W  = $clog2(WINDOW_LEN + 1);

   // interface widths
   localparam int LEG_W       = 2;
   localparam int HEAD_W      = 9;
   localparam int SPEED_W     = 10;
   localparam int LEG_TICKS_W = 16;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int CMP_W       = (TICK_BITS > LEG_TICKS_W) ? TICK_BITS : LEG_TICKS_W;

   // request operations
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // legs
   localparam logic [LEG_W-1:0] LEG_EAST      = 2'd0;
   localparam logic [LEG_W-1:0] LEG_SOUTH     = 2'd1;
   localparam logic [LEG_W-1:0] LEG_NORTHWEST = 2'd2;
   localparam logic [LEG_W-1:0] LEG_RECOVER   = 2'd3;

   // headings in degrees
   localparam logic signed [HEAD_W-1:0] HEAD_EAST      = 9'sd90;
   localparam logic signed [HEAD_W-1:0] HEAD_SOUTH     = 9'sd180;
   localparam logic signed [HEAD_W-1:0] HEAD_NORTHWEST = -9'sd45;
   localparam logic signed [HEAD_W-1:0] HEAD_RECOVER   = 9'sd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EAST_TICKS  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SOUTH_TICKS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRUISE      = 4'd2;

   // register reset values
   localparam logic [LEG_TICKS_W-1:0] EAST_TICKS_RST  = 16'd60;
   localparam logic [LEG_TICKS_W-1:0] SOUTH_TICKS_RST = 16'd60;
   localparam logic [SPEED_W-1:0]     CRUISE_RST      = 10'd150;

   // window unit result
   typedef struct packed {
      logic done;
      logic recover;
   } win_res_type;

endpackage

`default_nettype wire

### rtl/tlhs_sqdist.sv
// Bit-serial sum of squares |dx|^2 + |dy|^2, one multiplier bit per cycle.
// Depends on tlhs_pkg.
`default_nettype none

module tlhs_sqdist (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tlhs_pkg::MAG_W-1:0] mag_x,
   input  wire logic [tlhs_pkg::MAG_W-1:0] mag_y,
   output logic                            done,
   output logic [tlhs_pkg::SQ_W-1:0]       sq_sum
);

   localparam int CNT_W = $clog2(tlhs_pkg::MAG_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [tlhs_pkg::MAG_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [tlhs_pkg::MAG_W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [tlhs_pkg::SQ_W-1:0]  acc_ff, acc_in;
   logic [tlhs_pkg::SQ_W-1:0]  pp_x, pp_y;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      acc_in  = acc_ff;
      pp_x    = mx_ff[tlhs_pkg::MAG_W-1] ? tlhs_pkg::SQ_W'(ax_ff) : '0;
      pp_y    = my_ff[tlhs_pkg::MAG_W-1] ? tlhs_pkg::SQ_W'(ay_ff) : '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(tlhs_pkg::MAG_W);
         ax_in   = mag_x;
         ay_in   = mag_y;
         mx_in   = mag_x;
         my_in   = mag_y;
         acc_in  = '0;
      end else if (busy_ff) begin
         // msb first: shift accumulator, add both partial products
         acc_in = {acc_ff[tlhs_pkg::SQ_W-2:0], 1'b0} + pp_x + pp_y;
         mx_in  = {mx_ff[tlhs_pkg::MAG_W-2:0], 1'b0};
         my_in  = {my_ff[tlhs_pkg::MAG_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff  <= ax_in;
      ay_ff  <= ay_in;
      mx_ff  <= mx_in;
      my_ff  <= my_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign sq_sum = acc_ff;

endmodule

`default_nettype wire

### rtl/tlhs_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on tlhs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlhs_isqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tlhs_pkg::SQ_W-1:0]  radicand,
   output logic                            done,
   output logic [tlhs_pkg::DIST_W-1:0]     root
);

   localparam int CNT_W = $clog2(tlhs_pkg::DIST_W + 1);
   localparam int REM_W = tlhs_pkg::DIST_W + 1;
   localparam int WRK_W = REM_W + 2;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tlhs_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [tlhs_pkg::DIST_W-1:0] root_ff, root_in;
   logic [WRK_W-1:0]            wrk, trial, diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      wrk     = {rem_ff, rad_ff[tlhs_pkg::RAD_W-1 -: 2]};
      trial   = WRK_W'({root_ff, 2'b01});
      diff    = wrk - trial;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(tlhs_pkg::DIST_W);
         rad_in  = tlhs_pkg::RAD_W'(radicand);
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[tlhs_pkg::RAD_W-3:0], 2'b00};
         if (wrk >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[tlhs_pkg::DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = wrk[REM_W-1:0];
            root_in = {root_ff[tlhs_pkg::DIST_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

   `ASSERT_NEVER(a_isqrt_restart, start && busy_ff, "square root restarted while busy")

endmodule

`default_nettype wire

### rtl/tlhs_window.sv
// Distance window: ring memory, running sum, serial divide and minimum check.
// Depends on tlhs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tlhs_window (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tlhs_pkg::DIST_W-1:0] dist_val,
   output tlhs_pkg::win_res_type            res
);

   localparam int CNT_W  = $clog2(tlhs_pkg::SUM_W + 1);
   localparam int DREM_W = $clog2(tlhs_pkg::WINDOW_LEN);
   localparam int T_W    = DREM_W + 1;

   localparam logic [1:0] W_IDLE = 2'd0;
   localparam logic [1:0] W_DIV  = 2'd1;
   localparam logic [1:0] W_CMP  = 2'd2;

   logic [tlhs_pkg::DIST_W-1:0] mem [tlhs_pkg::WINDOW_LEN];
   logic [tlhs_pkg::DIST_W-1:0] old_ff;

   logic [1:0]                   state_ff, state_in;
   logic [tlhs_pkg::PTR_W-1:0]   ptr_ff, ptr_in;
   logic [tlhs_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [tlhs_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [tlhs_pkg::DIST_W-1:0]  min_ff, min_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [tlhs_pkg::SUM_W-1:0]   dvd_ff, dvd_in;
   logic [tlhs_pkg::SUM_W-1:0]   quo_ff, quo_in;
   logic [DREM_W-1:0]            drem_ff, drem_in;
   tlhs_pkg::win_res_type        res_ff, res_in;

   logic                         full, full_after, wr_en;
   logic [tlhs_pkg::SUM_W-1:0]   sum_new;
   logic [T_W-1:0]               t_val, t_sub;
   logic [tlhs_pkg::DIST_W-1:0]  avg;

   always_comb begin
      full       = fill_ff == tlhs_pkg::FILL_W'(tlhs_pkg::WINDOW_LEN);
      full_after = full || (fill_ff == tlhs_pkg::FILL_W'(tlhs_pkg::WINDOW_LEN - 1));
      sum_new    = sum_ff - (full ? tlhs_pkg::SUM_W'(old_ff) : '0)
                 + tlhs_pkg::SUM_W'(dist_val);
      t_val      = {drem_ff, dvd_ff[tlhs_pkg::SUM_W-1]};
      t_sub      = t_val - T_W'(tlhs_pkg::WINDOW_LEN);
      avg        = quo_ff[tlhs_pkg::DIST_W-1:0];

      state_in = state_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      quo_in   = quo_ff;
      drem_in  = drem_ff;
      res_in   = '0;
      wr_en    = 1'b0;

      case (state_ff)
         W_IDLE: begin
            if (start) begin
               wr_en  = 1'b1;
               sum_in = sum_new;
               if (fill_ff == '0) begin
                  min_in = dist_val;
               end
               if (!full) begin
                  fill_in = fill_ff + tlhs_pkg::FILL_W'(1);
               end
               if (ptr_ff == tlhs_pkg::PTR_W'(tlhs_pkg::WINDOW_LEN - 1)) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = ptr_ff + tlhs_pkg::PTR_W'(1);
               end
               if (full_after) begin
                  state_in = W_DIV;
                  cnt_in   = CNT_W'(tlhs_pkg::SUM_W);
                  dvd_in   = sum_new;
                  quo_in   = '0;
                  drem_in  = '0;
               end else begin
                  res_in.done = 1'b1;
               end
            end
         end
         W_DIV: begin
            // restoring divide by the window length, one quotient bit a cycle
            dvd_in = {dvd_ff[tlhs_pkg::SUM_W-2:0], 1'b0};
            if (t_val >= T_W'(tlhs_pkg::WINDOW_LEN)) begin
               drem_in = t_sub[DREM_W-1:0];
               quo_in  = {quo_ff[tlhs_pkg::SUM_W-2:0], 1'b1};
            end else begin
               drem_in = t_val[DREM_W-1:0];
               quo_in  = {quo_ff[tlhs_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = W_CMP;
            end
         end
         W_CMP: begin
            res_in.done = 1'b1;
            if (avg < min_ff) begin
               min_in = avg;
            end else begin
               res_in.recover = 1'b1;
            end
            state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // ring memory: entries hold nothing until written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= dist_val;
      end
      old_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         ptr_ff   <= '0;
         fill_ff  <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         cnt_ff   <= '0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         cnt_ff   <= cnt_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
   end

   assign res = res_ff;

   `ASSERT_ALWAYS(a_win_ptr_range,
      ptr_ff <= tlhs_pkg::PTR_W'(tlhs_pkg::WINDOW_LEN - 1), "window pointer out of range")
   `ASSERT_ALWAYS(a_win_fill_range,
      fill_ff <= tlhs_pkg::FILL_W'(tlhs_pkg::WINDOW_LEN), "window fill out of range")

endmodule

`default_nettype wire

### rtl/timed_leg_helm_sequencer_core.sv
// Timed-leg helm sequencer, top level: request handling, leg sequencer, result register.
// Depends on tlhs_pkg, tlhs_sqdist, tlhs_isqrt, tlhs_window and assert_macros.svh.
// Report: accepted, no response. East, south or recover tick: response in the cycle
// after acceptance, one request per cycle unless a held response stalls. Northwest
// tick: squares, root, window (divide and minimum check once full), input stalled.
// Synchronous active-high reset: east leg, window empty, registers at defaults.
`default_nettype none
`include "assert_macros.svh"

module timed_leg_helm_sequencer_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_operation,
   input  wire logic signed [tlhs_pkg::POS_W-1:0]      req_pos_x,
   input  wire logic signed [tlhs_pkg::POS_W-1:0]      req_pos_y,
   // response channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [tlhs_pkg::LEG_W-1:0]                  rsp_leg_now,
   output logic signed [tlhs_pkg::HEAD_W-1:0]          rsp_heading_deg,
   output logic [tlhs_pkg::SPEED_W-1:0]                rsp_speed_cmd,
   output logic                                        rsp_recover_now,
   // register write channel
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [tlhs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [tlhs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_RANGE = 1'b1;   // northwest tick in the serial units

   // registers
   logic [tlhs_pkg::LEG_TICKS_W-1:0] east_ticks_ff, east_ticks_in;
   logic [tlhs_pkg::LEG_TICKS_W-1:0] south_ticks_ff, south_ticks_in;
   logic [tlhs_pkg::SPEED_W-1:0]     cruise_ff, cruise_in;

   // sequencer state
   logic                             state_ff, state_in;
   logic [tlhs_pkg::LEG_W-1:0]       leg_ff, leg_in;
   logic [tlhs_pkg::TICK_BITS-1:0]   elapsed_ff, elapsed_in;
   logic                             have_start_ff, have_start_in;
   logic [tlhs_pkg::POS_W-1:0]       start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [tlhs_pkg::POS_W-1:0]       latest_x_ff, latest_x_in, latest_y_ff, latest_y_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [tlhs_pkg::LEG_W-1:0]       rsp_leg_ff;
   logic signed [tlhs_pkg::HEAD_W-1:0] rsp_head_ff;
   logic [tlhs_pkg::SPEED_W-1:0]     rsp_speed_ff;
   logic                             rsp_rec_ff;

   // internal
   logic                             req_fire, csr_fire;
   logic                             load_rsp, out_entered;
   logic [tlhs_pkg::LEG_W-1:0]       out_leg;
   logic signed [tlhs_pkg::HEAD_W-1:0] out_head;
   logic [tlhs_pkg::SPEED_W-1:0]     out_speed;
   logic [tlhs_pkg::TICK_BITS-1:0]   elapsed_inc;
   logic [tlhs_pkg::LEG_TICKS_W-1:0] leg_dur;
   logic                             leg_done;
   logic                             sq_start, sq_done, rt_done;
   logic [tlhs_pkg::POS_W:0]         dx, dy, ndx, ndy;
   logic [tlhs_pkg::MAG_W-1:0]       mag_x, mag_y;
   logic [tlhs_pkg::SQ_W-1:0]        sq_sum;
   logic [tlhs_pkg::DIST_W-1:0]      root;
   tlhs_pkg::win_res_type            win_res;

   // one request at a time; a held response also holds off the next request
   assign req_stall = (state_ff == ST_RANGE) | (rsp_valid_ff & rsp_stall);
   assign req_fire  = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // register writes, masked to width
   always_comb begin
      east_ticks_in  = east_ticks_ff;
      south_ticks_in = south_ticks_ff;
      cruise_in      = cruise_ff;
      if (csr_fire) begin
         case (csr_index)
            tlhs_pkg::REG_EAST_TICKS:  east_ticks_in  = csr_wdata;
            tlhs_pkg::REG_SOUTH_TICKS: south_ticks_in = csr_wdata;
            tlhs_pkg::REG_CRUISE:      cruise_in      = csr_wdata[tlhs_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // distance from start, magnitudes of the 25-bit differences fit 24 bits
   always_comb begin
      dx    = {latest_x_ff[tlhs_pkg::POS_W-1], latest_x_ff}
            - {start_x_ff[tlhs_pkg::POS_W-1], start_x_ff};
      dy    = {latest_y_ff[tlhs_pkg::POS_W-1], latest_y_ff}
            - {start_y_ff[tlhs_pkg::POS_W-1], start_y_ff};
      ndx   = -dx;
      ndy   = -dy;
      mag_x = dx[tlhs_pkg::POS_W] ? ndx[tlhs_pkg::MAG_W-1:0] : dx[tlhs_pkg::MAG_W-1:0];
      mag_y = dy[tlhs_pkg::POS_W] ? ndy[tlhs_pkg::MAG_W-1:0] : dy[tlhs_pkg::MAG_W-1:0];
   end

   // timed legs: saturating count, switch once past the duration
   always_comb begin
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff
                  : elapsed_ff + tlhs_pkg::TICK_BITS'(1);
      leg_dur     = (leg_ff == tlhs_pkg::LEG_EAST) ? east_ticks_ff : south_ticks_ff;
      leg_done    = tlhs_pkg::CMP_W'(elapsed_inc) > tlhs_pkg::CMP_W'(leg_dur);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      leg_in        = leg_ff;
      elapsed_in    = elapsed_ff;
      have_start_in = have_start_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      latest_x_in   = latest_x_ff;
      latest_y_in   = latest_y_ff;
      load_rsp      = 1'b0;
      out_leg       = leg_ff;
      out_entered   = 1'b0;
      sq_start      = 1'b0;

      if (req_fire && (req_operation == tlhs_pkg::OP_REPORT)) begin
         latest_x_in = req_pos_x;
         latest_y_in = req_pos_y;
         if (!have_start_ff) begin
            start_x_in    = req_pos_x;
            start_y_in    = req_pos_y;
            have_start_in = 1'b1;
         end
      end

      if (req_fire && (req_operation == tlhs_pkg::OP_TICK)) begin
         case (leg_ff)
            tlhs_pkg::LEG_EAST, tlhs_pkg::LEG_SOUTH: begin
               load_rsp = 1'b1;
               if (leg_done) begin
                  elapsed_in = '0;
                  out_leg    = (leg_ff == tlhs_pkg::LEG_EAST) ? tlhs_pkg::LEG_SOUTH
                             : tlhs_pkg::LEG_NORTHWEST;
                  leg_in     = out_leg;
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
            tlhs_pkg::LEG_NORTHWEST: begin
               state_in = ST_RANGE;
               sq_start = 1'b1;
            end
            default: begin
               load_rsp = 1'b1;   // recovery is terminal
            end
         endcase
      end

      if ((state_ff == ST_RANGE) && win_res.done) begin
         state_in = ST_IDLE;
         load_rsp = 1'b1;
         if (win_res.recover) begin
            leg_in      = tlhs_pkg::LEG_RECOVER;
            out_leg     = tlhs_pkg::LEG_RECOVER;
            out_entered = 1'b1;
         end
      end
   end

   // response fields from the updated leg
   always_comb begin
      out_speed = cruise_ff;
      case (out_leg)
         tlhs_pkg::LEG_EAST:      out_head = tlhs_pkg::HEAD_EAST;
         tlhs_pkg::LEG_SOUTH:     out_head = tlhs_pkg::HEAD_SOUTH;
         tlhs_pkg::LEG_NORTHWEST: out_head = tlhs_pkg::HEAD_NORTHWEST;
         default: begin
            out_head  = tlhs_pkg::HEAD_RECOVER;
            out_speed = '0;
         end
      endcase
      rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         east_ticks_ff  <= tlhs_pkg::EAST_TICKS_RST;
         south_ticks_ff <= tlhs_pkg::SOUTH_TICKS_RST;
         cruise_ff      <= tlhs_pkg::CRUISE_RST;
         state_ff       <= ST_IDLE;
         leg_ff         <= tlhs_pkg::LEG_EAST;
         elapsed_ff     <= '0;
         have_start_ff  <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         latest_x_ff    <= '0;
         latest_y_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         east_ticks_ff  <= east_ticks_in;
         south_ticks_ff <= south_ticks_in;
         cruise_ff      <= cruise_in;
         state_ff       <= state_in;
         leg_ff         <= leg_in;
         elapsed_ff     <= elapsed_in;
         have_start_ff  <= have_start_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         latest_x_ff    <= latest_x_in;
         latest_y_ff    <= latest_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_leg_ff   <= out_leg;
         rsp_head_ff  <= out_head;
         rsp_speed_ff <= out_speed;
         rsp_rec_ff   <= out_entered;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_leg_now     = rsp_leg_ff;
   assign rsp_heading_deg = rsp_head_ff;
   assign rsp_speed_cmd   = rsp_speed_ff;
   assign rsp_recover_now = rsp_rec_ff;

   // serial distance chain: squares, root, window
   tlhs_sqdist u_sqdist (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .mag_x  (mag_x),
      .mag_y  (mag_y),
      .done   (sq_done),
      .sq_sum (sq_sum)
   );

   tlhs_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_done),
      .radicand (sq_sum),
      .done     (rt_done),
      .root     (root)
   );

   tlhs_window u_window (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_done),
      .dist_val (root),
      .res      (win_res)
   );

   `ASSERT_ALWAYS(a_range_no_pending, (state_ff == ST_RANGE) |-> !rsp_valid_ff,
      "response pending during northwest tick")
   `ASSERT_ALWAYS(a_win_done_in_range, win_res.done |-> (state_ff == ST_RANGE),
      "window result outside northwest tick")

endmodule

`default_nettype wire
